// ===== hw/rtl/lbs_pkg.sv =====
// Shared types and constants for the two-frame linear blend stitch unit.
`timescale 1ns / 1ps
`default_nettype none
package lbs_pkg;

   // Field widths fixed by the transfer format.
   localparam int PIX_W  = 8;
   localparam int ROW_W  = 9;
   localparam int COL_W  = 11;
   localparam int OP_W   = 2;
   localparam int CFG_W  = 10;
   localparam int STEP_W = $clog2(PIX_W);

   // Configuration port geometry.
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   // Register indexes, taken from address bit 2.
   localparam logic REG_OVERLAP_START = 1'b0;
   localparam logic REG_VERT_OFFSET   = 1'b1;

   // Register reset values.
   localparam logic [CFG_W-1:0] OVERLAP_RESET = 10'd320;
   localparam logic [CFG_W-1:0] VERT_RESET    = 10'd0;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
   localparam logic [OP_W-1:0] OP_EMIT       = 2'd2;

   // Request payload.
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel;
   } lbs_req_type;

   // Response payload.
   typedef struct packed {
      logic [PIX_W-1:0] stitched_pixel;
      logic             in_range;
   } lbs_rsp_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic calc;
      logic addr;
      logic write;
      logic read;
      logic mul;
      logic div_start;
      logic out_load;
   } lbs_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ok;
      logic            use_l;
      logic            use_r;
      logic            div_busy;
      logic            out_free;
   } lbs_status_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_ADDR,
      ST_WRITE,
      ST_READ,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_DONE
   } lbs_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/two_frame_linear_blend_stitch_unit.sv =====
// Top level of the two-frame linear blend stitch unit with its register block.
//
// Usage: requests arrive on the req_ channel as valid/ready transfers. Operation
// load-left or load-right writes one pixel into the matching frame store; emit
// asks for one pixel of the stitched frame and produces one transfer on the rsp_
// channel. Loads outside the frame and the unused operation code produce nothing.
// Overlap start and vertical offset are written via the APB-style port; the user
// does this only while the unit is idle, unenforced; reads return stored values.
// Sequence: the controller works on one request at a time. A load passes calc,
// addr and write; an emit outside the stitched frame calc, addr and done; one
// left or right of the overlap calc, addr, read and done; one inside the overlap
// also mul, div start and div run, where the divider gives one quotient bit per
// cycle for the 8-bit blend. The output register loads as done is left.
// Reset clears the controller, the divider, the output valid and the registers
// (overlap start 320, offset 0); frame contents stay undefined until loaded.
// Stall: a result waiting in the output register does not block the next
// request; the controller only holds its final state while that register is
// still occupied and not taken.
`timescale 1ns / 1ps
`default_nettype none
module two_frame_linear_blend_stitch_unit #(
   parameter int WIDTH  = 640,
   parameter int HEIGHT = 480
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire lbs_pkg::lbs_req_type         req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output lbs_pkg::lbs_rsp_type              rsp_payload,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lbs_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [lbs_pkg::CSR_DW-1:0]   pwdata,
   output logic      [lbs_pkg::CSR_DW-1:0]   prdata,
   output logic                              pready
);
   import lbs_pkg::*;

   logic [CFG_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic             csr_write;
   lbs_cmd_type      cmd;
   lbs_status_type   status;

   // Register block.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      ax_in = ax_ff;
      ay_in = ay_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_OVERLAP_START: ax_in = pwdata[CFG_W-1:0];
            REG_VERT_OFFSET:   ay_in = pwdata[CFG_W-1:0];
            default:           ax_in = ax_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= OVERLAP_RESET;
         ay_ff <= VERT_RESET;
      end else begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_OVERLAP_START: prdata = CSR_DW'(ax_ff);
         REG_VERT_OFFSET:   prdata = CSR_DW'(ay_ff);
         default:           prdata = '0;
      endcase
   end

   // Controller.
   lbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   lbs_datapath #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .overlap_start (ax_ff),
      .vert_offset   (ay_ff),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

`ifndef SYNTHESIS
   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over a waiting transfer");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // An out-of-range answer carries a zero pixel.
   a_zero_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.in_range || rsp_payload.stitched_pixel == '0))
      else $error("nonzero pixel on out-of-range transfer");

   // A write to overlap start lands in the register.
   a_overlap_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && paddr[2] == REG_OVERLAP_START) |=> ax_ff == $past(pwdata[CFG_W-1:0]))
      else $error("overlap start write lost");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_frame_ram.sv =====
// Single-port-write, single-port-read frame memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lbs_frame_ram #(
   parameter int DEPTH = 307200,
   parameter int AW    = 19,
   parameter int DW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbs_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 10
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [NUM_W-1:0]         num,
   input  wire logic [DEN_W-1:0]         den,
   output logic                          busy,
   output logic [lbs_pkg::PIX_W-1:0]     quotient
);
   import lbs_pkg::*;

   logic             busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] dsh_ff, dsh_in;
   logic [PIX_W-1:0] quo_ff, quo_in;
   logic             fits;

   // One compare and subtract per cycle against the shifted divisor.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      fits    = rem_ff >= dsh_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(PIX_W - 1);
         rem_in  = num;
         dsh_in  = NUM_W'(den) << (PIX_W - 1);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[PIX_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_datapath.sv =====
// Datapath: request capture, address generation, frame memories, blend and output register.
`timescale 1ns / 1ps
`default_nettype none
module lbs_datapath #(
   parameter int WIDTH  = 640,
   parameter int HEIGHT = 480
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lbs_pkg::lbs_cmd_type        cmd,
   output lbs_pkg::lbs_status_type          status,
   input  wire logic [lbs_pkg::CFG_W-1:0]   overlap_start,
   input  wire logic [lbs_pkg::CFG_W-1:0]   vert_offset,
   input  wire lbs_pkg::lbs_req_type        req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output lbs_pkg::lbs_rsp_type             rsp_payload
);
   import lbs_pkg::*;

   localparam int DEPTH = WIDTH * HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CIW   = $clog2(WIDTH);
   localparam int RIW   = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
   localparam int CW    = $clog2(WIDTH + 2048);
   localparam int RW    = $clog2(HEIGHT + 1024);
   localparam int WGW   = $clog2(WIDTH + 1);
   localparam int NW    = WGW + PIX_W;

   lbs_req_type      req_ff;
   logic [RIW-1:0]   lrow_ff, lrow_in, rrow_ff, rrow_in;
   logic [CIW-1:0]   lcol_ff, lcol_in, rcol_ff, rcol_in;
   logic             ok_ff, ok_in, use_l_ff, use_l_in, use_r_ff, use_r_in;
   logic [WGW-1:0]   wl_ff, wl_in, wr_ff, wr_in, d_ff, d_in;
   logic [AW-1:0]    laddr_ff, raddr_ff;
   logic [NW-1:0]    prod_l_ff, prod_r_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   lbs_rsp_type      rsp_ff, rsp_in;

   logic [CW-1:0]    w_c, ax_ext, ax_eff, col_ext;
   logic [CFG_W-1:0] absy;
   logic             ay_neg;
   logic [RW-1:0]    row_ext, absy_ext, lshift, rshift;
   logic             frame_ok, load_ok;
   logic [PIX_W-1:0] left_pix, right_pix, quotient;
   logic             div_busy;

   // Capture the accepted request.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   // Geometry of the request against the stitched frame.
   always_comb begin
      w_c      = CW'(WIDTH);
      ax_ext   = CW'(overlap_start);
      ax_eff   = (ax_ext >= w_c) ? w_c - CW'(1) : ax_ext;
      col_ext  = CW'(req_ff.col);
      ay_neg   = vert_offset[CFG_W-1];
      absy     = ay_neg ? (~vert_offset + CFG_W'(1)) : vert_offset;
      row_ext  = RW'(req_ff.row);
      absy_ext = RW'(absy);
      lshift   = (!ay_neg) ? absy_ext : '0;
      rshift   = ay_neg ? absy_ext : '0;
      frame_ok = (row_ext + absy_ext < RW'(HEIGHT)) && (col_ext < w_c + ax_eff);
      load_ok  = (row_ext < RW'(HEIGHT)) && (col_ext < w_c);
      wl_in    = WGW'(w_c - col_ext);
      wr_in    = WGW'(col_ext - ax_eff);
      d_in     = WGW'(w_c - ax_eff);
      if (req_ff.op == OP_EMIT) begin
         lrow_in  = RIW'(row_ext + lshift);
         rrow_in  = RIW'(row_ext + rshift);
         lcol_in  = CIW'(col_ext);
         rcol_in  = CIW'(col_ext - ax_eff);
         ok_in    = frame_ok;
         use_l_in = col_ext < w_c;
         use_r_in = col_ext >= ax_eff;
      end else begin
         lrow_in  = RIW'(row_ext);
         rrow_in  = RIW'(row_ext);
         lcol_in  = CIW'(col_ext);
         rcol_in  = CIW'(col_ext);
         ok_in    = load_ok;
         use_l_in = 1'b0;
         use_r_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         lrow_ff  <= lrow_in;
         rrow_ff  <= rrow_in;
         lcol_ff  <= lcol_in;
         rcol_ff  <= rcol_in;
         ok_ff    <= ok_in;
         use_l_ff <= use_l_in;
         use_r_ff <= use_r_in;
         wl_ff    <= wl_in;
         wr_ff    <= wr_in;
         d_ff     <= d_in;
      end
   end

   // Linear addresses into both frames.
   always_ff @(posedge clock) begin
      if (cmd.addr) begin
         laddr_ff <= AW'(lrow_ff) * AW'(WIDTH) + AW'(lcol_ff);
         raddr_ff <= AW'(rrow_ff) * AW'(WIDTH) + AW'(rcol_ff);
      end
   end

   // Frame stores.
   lbs_frame_ram #(.DEPTH(DEPTH), .AW(AW), .DW(PIX_W)) u_left_ram (
      .clock   (clock),
      .wr_en   (cmd.write && ok_ff && req_ff.op == OP_LOAD_LEFT),
      .wr_addr (laddr_ff),
      .wr_data (req_ff.pixel),
      .rd_en   (cmd.read && use_l_ff),
      .rd_addr (laddr_ff),
      .rd_data (left_pix)
   );

   lbs_frame_ram #(.DEPTH(DEPTH), .AW(AW), .DW(PIX_W)) u_right_ram (
      .clock   (clock),
      .wr_en   (cmd.write && ok_ff && req_ff.op == OP_LOAD_RIGHT),
      .wr_addr (raddr_ff),
      .wr_data (req_ff.pixel),
      .rd_en   (cmd.read && use_r_ff),
      .rd_addr (raddr_ff),
      .rd_data (right_pix)
   );

   // Weighted products of the two overlapping pixels.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_l_ff <= NW'(wl_ff) * NW'(left_pix);
         prod_r_ff <= NW'(wr_ff) * NW'(right_pix);
      end
   end

   // The weights sum to the overlap width, so the quotient fits one pixel.
   lbs_div #(.NUM_W(NW), .DEN_W(WGW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (prod_l_ff + prod_r_ff),
      .den      (d_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Result selection by region.
   always_comb begin
      rsp_in.in_range = ok_ff;
      if (!ok_ff) begin
         rsp_in.stitched_pixel = '0;
      end else if (use_l_ff && use_r_ff) begin
         rsp_in.stitched_pixel = quotient;
      end else if (use_l_ff) begin
         rsp_in.stitched_pixel = left_pix;
      end else begin
         rsp_in.stitched_pixel = right_pix;
      end
   end

   // Output register; a waiting result holds until it is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to the controller.
   assign status.op       = req_ff.op;
   assign status.ok       = ok_ff;
   assign status.use_l    = use_l_ff;
   assign status.use_r    = use_r_ff;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ===== hw/rtl/lbs_ctrl.sv =====
// Controller state machine sequencing loads and emits through the datapath.
`timescale 1ns / 1ps
`default_nettype none
module lbs_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire lbs_pkg::lbs_status_type status,
   output lbs_pkg::lbs_cmd_type         cmd
);
   import lbs_pkg::*;

   lbs_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            priority if (status.op == OP_LOAD_LEFT || status.op == OP_LOAD_RIGHT) begin
               state_in = ST_WRITE;
            end else if (status.op == OP_EMIT) begin
               state_in = status.ok ? ST_READ : ST_DONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = (status.use_l && status.use_r) ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== bench/lbs_blend_checker.sv =====
// Checker that predicts stitched pixels from observed transfers and compares the results.
`timescale 1ns / 1ps
module lbs_blend_checker #(
   parameter int WIDTH  = 640,
   parameter int HEIGHT = 480
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  lbs_pkg::lbs_req_type           req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  lbs_pkg::lbs_rsp_type           rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lbs_pkg::CSR_AW-1:0]     paddr,
   input  logic [lbs_pkg::CSR_DW-1:0]     pwdata,
   input  logic [lbs_pkg::CSR_DW-1:0]     prdata,
   input  logic                           pready,
   output int                             mismatch_count,
   output int                             pending_results
);
   import lbs_pkg::*;

   // Private copies of both frame stores and of the two registers.
   bit [PIX_W-1:0]   left_px  [WIDTH*HEIGHT];
   bit [PIX_W-1:0]   right_px [WIDTH*HEIGHT];
   logic [CFG_W-1:0] overlap_reg;
   logic [CFG_W-1:0] vert_reg;

   // Expected stitched pixels, oldest emit first.
   lbs_rsp_type      expected_pixels [$];
   lbs_rsp_type      want;
   logic [CFG_W-1:0] reg_now;
   int               results_seen;
   int               px_index;

   // Every mismatch prints one line and bumps the count.
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] stitch check: %s", $time, msg);
   endtask

   // Stitched pixel for one emit under the current registers and frame contents.
   function automatic lbs_rsp_type stitched_value(input lbs_req_type rq);
      lbs_rsp_type res;
      int ax, ay, abs_ay, row, col, lr, rr, lval, rval;
      res = '0;
      row = rq.row;
      col = rq.col;
      ax = overlap_reg;
      if (ax >= WIDTH) ax = WIDTH - 1;
      ay = $signed(vert_reg);
      abs_ay = (ay < 0) ? -ay : ay;
      if (abs_ay < HEIGHT && row < HEIGHT - abs_ay && col < WIDTH + ax) begin
         lr = row + ((ay > 0) ? ay : 0);
         rr = row + ((ay < 0) ? abs_ay : 0);
         res.in_range = 1'b1;
         if (col < ax) begin
            res.stitched_pixel = left_px[lr*WIDTH + col];
         end else if (col < WIDTH) begin
            // Overlap: exact integer feather between the two frames.
            lval = left_px[lr*WIDTH + col];
            rval = right_px[rr*WIDTH + col - ax];
            res.stitched_pixel = PIX_W'(((WIDTH - col) * lval + (col - ax) * rval) /
                                        (WIDTH - ax));
         end else begin
            res.stitched_pixel = right_px[rr*WIDTH + col - ax];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         overlap_reg <= OVERLAP_RESET;
         vert_reg <= VERT_RESET;
         expected_pixels.delete();
         results_seen = 0;
         mismatch_count = 0;
         pending_results <= 0;
      end else begin
         // Register port: track writes, check read data against the stored value.
         if (psel && penable && pready) begin
            if (pwrite) begin
               if (paddr[2] == REG_OVERLAP_START) overlap_reg <= pwdata[CFG_W-1:0];
               else vert_reg <= pwdata[CFG_W-1:0];
            end else begin
               reg_now = (paddr[2] == REG_OVERLAP_START) ? overlap_reg : vert_reg;
               if (prdata[CFG_W-1:0] !== reg_now)
                  report_mismatch($sformatf("register read at 0x%0h gave 0x%0h, expected 0x%0h",
                                            paddr, prdata[CFG_W-1:0], reg_now));
            end
         end

         // Result transfer: compare with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no emit outstanding",
                                         results_seen));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_payload.stitched_pixel !== want.stitched_pixel)
                  report_mismatch($sformatf("result %0d stitched_pixel %0d, expected %0d",
                                            results_seen, rsp_payload.stitched_pixel,
                                            want.stitched_pixel));
               if (rsp_payload.in_range !== want.in_range)
                  report_mismatch($sformatf("result %0d in_range %0b, expected %0b",
                                            results_seen, rsp_payload.in_range,
                                            want.in_range));
            end
         end

         // Request transfer: update the frame copies or predict an emit.
         if (req_valid && req_ready) begin
            px_index = req_payload.row * WIDTH + req_payload.col;
            case (req_payload.op)
               OP_LOAD_LEFT: begin
                  if (req_payload.row < HEIGHT && req_payload.col < WIDTH)
                     left_px[px_index] = req_payload.pixel;
               end
               OP_LOAD_RIGHT: begin
                  if (req_payload.row < HEIGHT && req_payload.col < WIDTH)
                     right_px[px_index] = req_payload.pixel;
               end
               OP_EMIT: begin
                  expected_pixels.push_back(stitched_value(req_payload));
               end
               default: begin
               end
            endcase
         end

         pending_results <= expected_pixels.size();
      end
   end

endmodule

// ===== bench/two_frame_linear_blend_stitch_unit_tb.sv =====
// Top of the stitch unit testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module two_frame_linear_blend_stitch_unit_tb;
   import lbs_pkg::*;

   localparam int WIDTH             = 640;
   localparam int HEIGHT            = 480;
   localparam int HALF_PERIOD       = 5;
   localparam int LIMIT_CYCLES      = 400000;
   localparam int SETTLE_CYCLES     = 24;
   localparam int TAIL_CYCLES       = 40;
   localparam int HOLD_CYCLES       = 400;
   localparam int PLAN_SETTINGS     = 7;
   localparam int ITEMS_PER_SETTING = 84;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   lbs_req_type       req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   lbs_rsp_type       rsp_payload;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int mismatch_count;
   int pending_results;
   int tx_idle_pct;
   int rx_idle_pct;
   int hold_requests = 0;
   int cur_ax;
   int cur_ay;
   int transfers = 0;
   int useful_items = 0;
   int emits = 0;
   int loads = 0;
   int settings_seen = 1;
   int cycles = 0;

   // Which pixels of each frame have been loaded, so emits never read stale memory.
   bit left_set  [WIDTH*HEIGHT];
   bit right_set [WIDTH*HEIGHT];

   // Register values for the planned phases; the last two are drawn at random.
   int plan_ax_codes [PLAN_SETTINGS] = '{0, 639, 1023, 17, 640, 0, 0};
   int plan_ay_codes [PLAN_SETTINGS] = '{0, 479, 545, 512, 480, 0, 0};

   two_frame_linear_blend_stitch_unit #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lbs_blend_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) blend_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .mismatch_count(mismatch_count), .pending_results(pending_results)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("two_frame_linear_blend_stitch_unit: mismatch");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold whenever one is requested.
   initial begin : receiver
      int hold_left;
      int holds_served;
      rsp_ready = 1'b0;
      hold_left = 0;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Offers one request and waits for its transfer.
   task automatic send_req(input logic [OP_W-1:0] op, input int row, input int col,
                           input int pixel);
      lbs_req_type item;
      item.op = op;
      item.row = ROW_W'(row);
      item.col = COL_W'(col);
      item.pixel = PIX_W'(pixel);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      transfers++;
      if (op == OP_EMIT) begin
         emits++;
         useful_items++;
      end else if ((op == OP_LOAD_LEFT || op == OP_LOAD_RIGHT) && row < HEIGHT && col < WIDTH)
      begin
         loads++;
         useful_items++;
         if (op == OP_LOAD_LEFT) left_set[row*WIDTH + col] = 1'b1;
         else right_set[row*WIDTH + col] = 1'b1;
      end
   endtask

   // Stops offering requests and waits until every emit has been answered.
   task automatic drain(input int extra);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input int value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      // Keep the effective geometry for choosing legal emits.
      if (reg_sel == REG_OVERLAP_START) begin
         cur_ax = value[CFG_W-1:0];
         if (cur_ax >= WIDTH) cur_ax = WIDTH - 1;
      end else begin
         cur_ay = value[CFG_W-1:0];
         if (cur_ay >= 512) cur_ay -= 1024;
      end
   endtask

   task automatic csr_read(input logic reg_sel);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_sel, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Loads whatever source pixels the emit needs, then sends the emit itself.
   task automatic emit_at(input int row, input int col, input bit refresh);
      int abs_ay, lr, rr;
      abs_ay = (cur_ay < 0) ? -cur_ay : cur_ay;
      lr = row + ((cur_ay > 0) ? cur_ay : 0);
      rr = row + ((cur_ay < 0) ? abs_ay : 0);
      if (row < HEIGHT - abs_ay && col < WIDTH + cur_ax) begin
         if (col < WIDTH && (refresh || !left_set[lr*WIDTH + col]))
            send_req(OP_LOAD_LEFT, lr, col, $urandom_range(255));
         if (col >= cur_ax && (refresh || !right_set[rr*WIDTH + col - cur_ax]))
            send_req(OP_LOAD_RIGHT, rr, col - cur_ax, $urandom_range(255));
      end
      send_req(OP_EMIT, row, col, $urandom_range(255));
   endtask

   // One random step: mostly load-then-emit sequences, the rest noise.
   task automatic random_item();
      int pick, ms, row, col;
      pick = $urandom_range(99);
      ms = HEIGHT - ((cur_ay < 0) ? -cur_ay : cur_ay);
      if (pick < 68 && ms > 0) begin
         // Target inside the stitched frame, rows mostly in a small hot window.
         if ($urandom_range(3) == 0) row = $urandom_range(ms - 1);
         else row = $urandom_range((ms < 8) ? ms - 1 : 7);
         case ($urandom_range(5))
            0: col = (cur_ax > 0) ? $urandom_range(cur_ax - 1) : 0;
            1: col = (cur_ax > 0) ? WIDTH + $urandom_range(cur_ax - 1) : WIDTH - 1;
            2: col = cur_ax;
            3: col = WIDTH - 1;
            default: col = $urandom_range(WIDTH - 1, cur_ax);
         endcase
         emit_at(row, col, $urandom_range(1));
      end else if (pick < 80) begin
         // Emit that falls outside the stitched frame.
         if (ms <= 0) begin
            row = $urandom_range(511);
            col = $urandom_range(2047);
         end else if ($urandom_range(1)) begin
            row = $urandom_range(511, ms);
            col = $urandom_range(2047);
         end else begin
            row = $urandom_range(511);
            col = $urandom_range(2047, WIDTH + cur_ax);
         end
         send_req(OP_EMIT, row, col, $urandom_range(255));
      end else if (pick < 94) begin
         // Plain load, sometimes outside the frame.
         send_req($urandom_range(1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT, $urandom_range(511),
                  ($urandom_range(3) == 0) ? $urandom_range(2047) : $urandom_range(WIDTH - 1),
                  $urandom_range(255));
      end else begin
         send_req(OP_UNUSED, $urandom_range(511), $urandom_range(2047), $urandom_range(255));
      end
   endtask

   initial begin : stimulus
      int setting, target, plan_ax, plan_ay;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      tx_idle_pct = 24;
      rx_idle_pct = 88;
      cur_ax = OVERLAP_RESET;
      cur_ay = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Reset values of both registers.
      csr_read(REG_OVERLAP_START);
      csr_read(REG_VERT_OFFSET);

      // Directed part under the reset geometry: region edges and extreme values.
      send_req(OP_LOAD_LEFT, 0, 0, 255);
      send_req(OP_LOAD_RIGHT, 0, 0, 255);
      send_req(OP_LOAD_LEFT, 0, 320, 0);
      send_req(OP_LOAD_LEFT, HEIGHT - 1, WIDTH - 1, 255);
      send_req(OP_LOAD_RIGHT, HEIGHT - 1, WIDTH - 1, 0);
      send_req(OP_LOAD_LEFT, 0, 500, 255);
      send_req(OP_LOAD_RIGHT, 0, 180, 255);
      emit_at(0, 0, 1'b0);
      emit_at(0, 319, 1'b0);
      emit_at(0, 320, 1'b0);
      emit_at(0, 500, 1'b0);
      emit_at(HEIGHT - 1, WIDTH - 1, 1'b0);
      emit_at(HEIGHT - 1, WIDTH, 1'b0);
      emit_at(HEIGHT - 1, WIDTH + 319, 1'b0);
      // Requests outside the stitched frame.
      send_req(OP_EMIT, 0, WIDTH + 320, 0);
      send_req(OP_EMIT, HEIGHT, 0, 255);
      send_req(OP_EMIT, 511, 2047, 255);
      // Loads outside the frame and the unused operation are dropped.
      send_req(OP_LOAD_LEFT, HEIGHT, 0, 255);
      send_req(OP_LOAD_RIGHT, 0, WIDTH, 255);
      send_req(OP_LOAD_LEFT, 511, 2047, 0);
      send_req(OP_UNUSED, 511, 2047, 255);

      // Random part across several register settings and idling phases.
      for (setting = 0; setting < PLAN_SETTINGS; setting++) begin
         if (setting == 2) begin
            tx_idle_pct = 88;
            rx_idle_pct = 24;
         end
         if (setting == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         plan_ax = plan_ax_codes[setting];
         plan_ay = plan_ay_codes[setting];
         if (setting >= 5) begin
            plan_ax = $urandom_range(638, 1);
            plan_ay = ($urandom_range(598) + 1024 - 299) % 1024;
         end
         drain(SETTLE_CYCLES);
         csr_write(REG_OVERLAP_START, plan_ax);
         csr_write(REG_VERT_OFFSET, plan_ay);
         csr_read(REG_OVERLAP_START);
         csr_read(REG_VERT_OFFSET);
         settings_seen++;
         target = useful_items + ITEMS_PER_SETTING;
         if (setting == 5) begin
            // Hold results back while overlap emits keep coming, then let it all drain.
            hold_requests++;
            repeat (30) emit_at($urandom_range(7), $urandom_range(WIDTH - 1, cur_ax), 1'b1);
            drain(0);
         end
         while (useful_items < target) random_item();
      end

      drain(TAIL_CYCLES);
      $display("Covered %0d transfers (%0d emits, %0d in-frame loads) over %0d register settings.",
               transfers, emits, loads, settings_seen);
      $display("Idling ran slow receiver, slow sender, then none, with a %0d-cycle result hold.",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("two_frame_linear_blend_stitch_unit: match");
      end else begin
         $display("two_frame_linear_blend_stitch_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_frame_ram.sv
hw/rtl/lbs_div.sv
hw/rtl/lbs_datapath.sv
hw/rtl/lbs_ctrl.sv
hw/rtl/two_frame_linear_blend_stitch_unit.sv
bench/lbs_blend_checker.sv
bench/two_frame_linear_blend_stitch_unit_tb.sv
